// ===== sv/ssfs_pkg.sv =====
package ssfs_pkg;

	localparam int DELTA_W    = 16;
	localparam int FRAME_W    = 12;
	localparam int COL_W      = 6;
	localparam int ROW_W      = 13;
	localparam int SCALE_W    = 17;
	localparam int OFFSET_W   = 32;
	localparam int COUNT_W    = 13;
	localparam int PERIOD_W   = 24;
	localparam int SIDE_W     = 7;
	localparam int START_W    = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int STEP_W     = 5;
	localparam int MUL_A_W    = 13;
	localparam int PROD_W     = MUL_A_W + PERIOD_W;

	localparam logic [SCALE_W-1:0] Q16_ONE   = 17'h10000;
	localparam logic [COUNT_W-1:0] FRAME_CAP = 13'd4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLUMNS      = 3'd0,
		REG_ROWS         = 3'd1,
		REG_FRAME_LIMIT  = 3'd2,
		REG_FRAME_PERIOD = 3'd3,
		REG_LOOPING      = 3'd4,
		REG_START_FRAME  = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_ACCUM,
		ACT_LOAD_REM,
		ACT_FRAME_REM,
		ACT_ADVANCE,
		ACT_STOP,
		ACT_SAVE_CR,
		ACT_SAVE_SX,
		ACT_SAVE_SY,
		ACT_SAVE_OX,
		ACT_FINISH,
		ACT_FINISH_IDLE
	} act_t;

	typedef enum logic [2:0] {
		DIV_NONE,
		DIV_TIME,
		DIV_WRAP,
		DIV_COLROW,
		DIV_SCALEX,
		DIV_SCALEY
	} div_op_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_STEPS,
		MUL_X,
		MUL_Y
	} mul_op_t;

	typedef enum logic [2:0] {
		CND_NEVER,
		CND_ALWAYS,
		CND_IDLE_SHEET,
		CND_NO_PERIOD,
		CND_NO_LOOP,
		CND_Q_ZERO,
		CND_Q_GE_STEPS
	} cond_t;

	typedef struct packed {
		act_t              act;
		div_op_t           div_op;
		mul_op_t           mul_op;
		cond_t             cond;
		logic              wait_div;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic                updated;
		logic [FRAME_W-1:0]  frame;
		logic [COL_W-1:0]    column;
		logic [ROW_W-1:0]    row;
		logic                playing;
		logic [SCALE_W-1:0]  uv_scale_x;
		logic [SCALE_W-1:0]  uv_scale_y;
		logic [OFFSET_W-1:0] uv_offset_x;
		logic [OFFSET_W-1:0] uv_offset_y;
	} res_t;

	localparam logic [STEP_W-1:0] STEP_CHK        = 5'd0;
	localparam logic [STEP_W-1:0] STEP_ACCUM      = 5'd1;
	localparam logic [STEP_W-1:0] STEP_DIV_TIME   = 5'd2;
	localparam logic [STEP_W-1:0] STEP_WAIT_TIME  = 5'd3;
	localparam logic [STEP_W-1:0] STEP_MODE       = 5'd4;
	localparam logic [STEP_W-1:0] STEP_LOOP       = 5'd5;
	localparam logic [STEP_W-1:0] STEP_DIV_WRAP   = 5'd6;
	localparam logic [STEP_W-1:0] STEP_WAIT_WRAP  = 5'd7;
	localparam logic [STEP_W-1:0] STEP_WRAP       = 5'd8;
	localparam logic [STEP_W-1:0] STEP_ONCE       = 5'd9;
	localparam logic [STEP_W-1:0] STEP_ADVANCE    = 5'd10;
	localparam logic [STEP_W-1:0] STEP_STOP       = 5'd11;
	localparam logic [STEP_W-1:0] STEP_STOP_APPLY = 5'd12;
	localparam logic [STEP_W-1:0] STEP_GEOM       = 5'd13;
	localparam logic [STEP_W-1:0] STEP_WAIT_CR    = 5'd14;
	localparam logic [STEP_W-1:0] STEP_SCALE_X    = 5'd15;
	localparam logic [STEP_W-1:0] STEP_WAIT_SX    = 5'd16;
	localparam logic [STEP_W-1:0] STEP_SCALE_Y    = 5'd17;
	localparam logic [STEP_W-1:0] STEP_WAIT_SY    = 5'd18;
	localparam logic [STEP_W-1:0] STEP_MUL_X      = 5'd19;
	localparam logic [STEP_W-1:0] STEP_MUL_Y      = 5'd20;
	localparam logic [STEP_W-1:0] STEP_FINISH     = 5'd21;
	localparam logic [STEP_W-1:0] STEP_NOUPD      = 5'd22;

	localparam ctrl_t CTRL_NOP = '{
		act:      ACT_NONE,
		div_op:   DIV_NONE,
		mul_op:   MUL_NONE,
		cond:     CND_NEVER,
		wait_div: 1'b0,
		target:   STEP_CHK
	};

	// Control store: one word per step, jumps taken when cond holds.
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] pc);
		ctrl_t c;
		c = CTRL_NOP;
		unique case (pc)
			STEP_CHK: begin
				c.cond   = CND_IDLE_SHEET;
				c.target = STEP_NOUPD;
			end
			STEP_ACCUM: begin
				c.act    = ACT_ACCUM;
				c.cond   = CND_NO_PERIOD;
				c.target = STEP_GEOM;
			end
			STEP_DIV_TIME:  c.div_op = DIV_TIME;
			STEP_WAIT_TIME: c.wait_div = 1'b1;
			STEP_MODE: begin
				c.cond   = CND_NO_LOOP;
				c.target = STEP_ONCE;
			end
			STEP_LOOP: begin
				c.act    = ACT_LOAD_REM;
				c.cond   = CND_Q_ZERO;
				c.target = STEP_GEOM;
			end
			STEP_DIV_WRAP:  c.div_op = DIV_WRAP;
			STEP_WAIT_WRAP: c.wait_div = 1'b1;
			STEP_WRAP: begin
				c.act    = ACT_FRAME_REM;
				c.cond   = CND_ALWAYS;
				c.target = STEP_GEOM;
			end
			STEP_ONCE: begin
				c.cond   = CND_Q_GE_STEPS;
				c.target = STEP_STOP;
			end
			STEP_ADVANCE: begin
				c.act    = ACT_ADVANCE;
				c.cond   = CND_ALWAYS;
				c.target = STEP_GEOM;
			end
			STEP_STOP:       c.mul_op = MUL_STEPS;
			STEP_STOP_APPLY: c.act = ACT_STOP;
			STEP_GEOM:       c.div_op = DIV_COLROW;
			STEP_WAIT_CR:    c.wait_div = 1'b1;
			STEP_SCALE_X: begin
				c.act    = ACT_SAVE_CR;
				c.div_op = DIV_SCALEX;
			end
			STEP_WAIT_SX: c.wait_div = 1'b1;
			STEP_SCALE_Y: begin
				c.act    = ACT_SAVE_SX;
				c.div_op = DIV_SCALEY;
			end
			STEP_WAIT_SY: c.wait_div = 1'b1;
			STEP_MUL_X: begin
				c.act    = ACT_SAVE_SY;
				c.mul_op = MUL_X;
			end
			STEP_MUL_Y: begin
				c.act    = ACT_SAVE_OX;
				c.mul_op = MUL_Y;
			end
			STEP_FINISH: c.act = ACT_FINISH;
			STEP_NOUPD:  c.act = ACT_FINISH_IDLE;
			default: begin
				c.cond   = CND_ALWAYS;
				c.target = STEP_NOUPD;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== sv/ssfs_ifs.sv =====
interface ssfs_step_if import ssfs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DELTA_W-1:0] delta_time;
	logic               restart;

	modport source(output valid, delta_time, restart, input ready);
	modport sink(input valid, delta_time, restart, output ready);
endinterface

interface ssfs_result_if import ssfs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                updated;
	logic [FRAME_W-1:0]  frame;
	logic [COL_W-1:0]    column;
	logic [ROW_W-1:0]    row;
	logic                playing;
	logic [SCALE_W-1:0]  uv_scale_x;
	logic [SCALE_W-1:0]  uv_scale_y;
	logic [OFFSET_W-1:0] uv_offset_x;
	logic [OFFSET_W-1:0] uv_offset_y;

	modport source(output valid, updated, frame, column, row, playing,
		uv_scale_x, uv_scale_y, uv_offset_x, uv_offset_y, input ready);
	modport sink(input valid, updated, frame, column, row, playing,
		uv_scale_x, uv_scale_y, uv_offset_x, uv_offset_y, output ready);
endinterface

// ===== sv/sprite_sheet_frame_sequencer.sv =====
// Channel  Side  Handshake      Payload
// step     in    valid/ready    delta_time, restart
// result   out   valid/ready    updated, frame, column, row, playing, uv_scale/offset
// cfg      in    cfg_we         cfg_index, cfg_data (write only)
//
// One step request at a time. Updates run on a single bit-serial divider, one quotient
// bit per cycle, shared by the period, wrap, column/row and UV scale divisions.
// Reset (arst_n low) restores the register defaults, frame 0, time 0, playing.
// A new request is taken while the last result still waits in the output register;
// the program then holds on its final step until that register frees up.
module sprite_sheet_frame_sequencer import ssfs_pkg::*; #(
	parameter int MAX_SIDE  = 64,
	parameter int TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ssfs_step_if.sink             step,
	ssfs_result_if.source         result
);

	localparam int DV_W  = TIME_BITS + 1;
	localparam int CNT_W = $clog2(DV_W + 1);
	localparam int SUB_W = (TIME_BITS > PROD_W) ? TIME_BITS : PROD_W;
	localparam logic [SIDE_W-1:0] SIDE_CLIP = (MAX_SIDE > 127) ? 7'd127 : 7'(MAX_SIDE);

	// configuration
	logic [SIDE_W-1:0]   columns_q, rows_q;
	logic [COUNT_W-1:0]  frame_limit_q;
	logic [PERIOD_W-1:0] frame_period_q;
	logic                looping_q;
	logic [START_W-1:0]  start_frame_q;

	// animation state
	logic [TIME_BITS-1:0] elapsed_q;
	logic [FRAME_W-1:0]   frame_q;
	logic                 running_q;

	// sequencer
	logic              busy_q;
	logic [STEP_W-1:0] pc_q;
	ctrl_t             ctrl;
	logic              accept, hold, advance, finishing, out_free, cond_true;

	// datapath
	logic [DELTA_W-1:0]  delta_q;
	logic [SIDE_W-1:0]   cols_c, rws_c;
	logic [13:0]         total_c, lim_c;
	logic [COUNT_W-1:0]  count_c, count_q, steps_c;
	logic                f_over;
	logic [TIME_BITS-1:0] q_c;
	logic [DV_W-1:0]     sum_c, wrap_c;
	logic [COUNT_W-1:0]  absf_c;
	logic [SCALE_W-1:0]  numx_c, numy_c;

	// divider
	logic [CNT_W-1:0]    div_cnt_q;
	logic                div_busy;
	logic [DV_W-1:0]     quo_q;
	logic [PERIOD_W-1:0] rem_q, dvs_q;
	logic [PERIOD_W:0]   shifted_c;
	logic [PERIOD_W+1:0] trial_c;

	// multiplier
	logic [MUL_A_W-1:0]  mul_a;
	logic [PERIOD_W-1:0] mul_b;
	logic [PROD_W-1:0]   prod_q;

	// working results
	logic [SIDE_W-1:0]   col_q;
	logic [ROW_W-1:0]    row_q;
	logic [SCALE_W-1:0]  sx_q, sy_q;
	logic [OFFSET_W-1:0] ox_q;

	logic out_valid_q;
	res_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q      <= 7'd1;
			rows_q         <= 7'd1;
			frame_limit_q  <= '0;
			frame_period_q <= 24'd1000;
			looping_q      <= 1'b1;
			start_frame_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLUMNS:      columns_q      <= cfg_data[SIDE_W-1:0];
				REG_ROWS:         rows_q         <= cfg_data[SIDE_W-1:0];
				REG_FRAME_LIMIT:  frame_limit_q  <= cfg_data[COUNT_W-1:0];
				REG_FRAME_PERIOD: frame_period_q <= cfg_data[PERIOD_W-1:0];
				REG_LOOPING:      looping_q      <= cfg_data[0];
				REG_START_FRAME:  start_frame_q  <= cfg_data[START_W-1:0];
				default: ;
			endcase
		end
	end

	// sheet geometry and effective frame count
	always_comb begin
		cols_c  = (int'(columns_q) > MAX_SIDE) ? SIDE_CLIP : columns_q;
		rws_c   = (int'(rows_q) > MAX_SIDE) ? SIDE_CLIP : rows_q;
		total_c = 14'(cols_c) * 14'(rws_c);
		lim_c   = (frame_limit_q != '0 && 14'(frame_limit_q) < total_c) ?
			14'(frame_limit_q) : total_c;
		count_c = (lim_c > 14'(FRAME_CAP)) ? FRAME_CAP : lim_c[COUNT_W-1:0];
	end

	always_ff @(posedge clk) begin
		count_q <= count_c;
	end

	assign f_over  = {1'b0, frame_q} >= count_q;
	assign steps_c = f_over ? 13'd1 : count_q - {1'b0, frame_q};
	assign q_c     = quo_q[TIME_BITS-1:0];
	assign sum_c   = {1'b0, elapsed_q} + DV_W'(delta_q);
	assign wrap_c  = f_over ? DV_W'(q_c) - DV_W'(1) : DV_W'(q_c) + DV_W'(frame_q);
	assign absf_c  = COUNT_W'(start_frame_q) + COUNT_W'(frame_q);
	assign numx_c  = Q16_ONE + SCALE_W'(cols_c >> 1);
	assign numy_c  = Q16_ONE + SCALE_W'(rws_c >> 1);

	// sequencer control
	assign ctrl       = ucode(pc_q);
	assign step.ready = !busy_q;
	assign accept     = step.valid && !busy_q;
	assign div_busy   = div_cnt_q != '0;
	assign out_free   = !out_valid_q || result.ready;
	assign finishing  = ctrl.act == ACT_FINISH || ctrl.act == ACT_FINISH_IDLE;
	assign hold       = (ctrl.wait_div && div_busy) || (finishing && !out_free);
	assign advance    = busy_q && !hold;

	always_comb begin
		unique case (ctrl.cond)
			CND_NEVER:      cond_true = 1'b0;
			CND_ALWAYS:     cond_true = 1'b1;
			CND_IDLE_SHEET: cond_true = !running_q || cols_c == '0 || rws_c == '0;
			CND_NO_PERIOD:  cond_true = frame_period_q == '0;
			CND_NO_LOOP:    cond_true = !looping_q;
			CND_Q_ZERO:     cond_true = q_c == '0;
			CND_Q_GE_STEPS: cond_true = q_c >= TIME_BITS'(steps_c);
			default:        cond_true = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= STEP_CHK;
		end else if (accept) begin
			busy_q <= 1'b1;
			pc_q   <= STEP_CHK;
		end else if (advance) begin
			if (finishing) begin
				busy_q <= 1'b0;
			end else if (cond_true) begin
				pc_q <= ctrl.target;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			delta_q <= step.delta_time;
		end
	end

	// animation state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			frame_q   <= '0;
			running_q <= 1'b1;
		end else if (accept) begin
			if (step.restart) begin
				elapsed_q <= '0;
				frame_q   <= '0;
				running_q <= 1'b1;
			end
		end else if (advance) begin
			unique case (ctrl.act)
				ACT_ACCUM:     elapsed_q <= sum_c[TIME_BITS] ? '1 : sum_c[TIME_BITS-1:0];
				ACT_LOAD_REM:  elapsed_q <= TIME_BITS'(rem_q);
				ACT_FRAME_REM: frame_q   <= rem_q[FRAME_W-1:0];
				ACT_ADVANCE: begin
					frame_q   <= frame_q + q_c[FRAME_W-1:0];
					elapsed_q <= TIME_BITS'(rem_q);
				end
				ACT_STOP: begin
					// drop only the periods spent reaching the last frame
					elapsed_q <= TIME_BITS'(SUB_W'(elapsed_q) - SUB_W'(prod_q));
					frame_q   <= FRAME_W'(count_q - 1'b1);
					running_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// bit-serial restoring divider, dividend left-aligned in quo_q
	assign shifted_c = {rem_q, quo_q[DV_W-1]};
	assign trial_c   = {1'b0, shifted_c} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (advance && ctrl.div_op != DIV_NONE) begin
			unique case (ctrl.div_op)
				DIV_TIME:   div_cnt_q <= CNT_W'(TIME_BITS);
				DIV_WRAP:   div_cnt_q <= CNT_W'(DV_W);
				DIV_COLROW: div_cnt_q <= CNT_W'(COUNT_W);
				default:    div_cnt_q <= CNT_W'(SCALE_W);
			endcase
		end else if (div_busy) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctrl.div_op != DIV_NONE) begin
			rem_q <= '0;
			unique case (ctrl.div_op)
				DIV_TIME: begin
					quo_q <= DV_W'(elapsed_q) << 1;
					dvs_q <= frame_period_q;
				end
				DIV_WRAP: begin
					quo_q <= wrap_c;
					dvs_q <= PERIOD_W'(count_q);
				end
				DIV_COLROW: begin
					quo_q <= DV_W'(absf_c) << (DV_W - COUNT_W);
					dvs_q <= PERIOD_W'(cols_c);
				end
				DIV_SCALEX: begin
					quo_q <= DV_W'(numx_c) << (DV_W - SCALE_W);
					dvs_q <= PERIOD_W'(cols_c);
				end
				default: begin
					quo_q <= DV_W'(numy_c) << (DV_W - SCALE_W);
					dvs_q <= PERIOD_W'(rws_c);
				end
			endcase
		end else if (div_busy) begin
			if (!trial_c[PERIOD_W+1]) begin
				rem_q <= trial_c[PERIOD_W-1:0];
				quo_q <= {quo_q[DV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted_c[PERIOD_W-1:0];
				quo_q <= {quo_q[DV_W-2:0], 1'b0};
			end
		end
	end

	// shared multiplier, product registered
	always_comb begin
		unique case (ctrl.mul_op)
			MUL_X: begin
				mul_a = MUL_A_W'(col_q);
				mul_b = PERIOD_W'(sx_q);
			end
			MUL_Y: begin
				mul_a = row_q;
				mul_b = PERIOD_W'(sy_q);
			end
			default: begin
				mul_a = steps_c;
				mul_b = frame_period_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance && ctrl.mul_op != MUL_NONE) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			unique case (ctrl.act)
				ACT_SAVE_CR: begin
					col_q <= rem_q[SIDE_W-1:0];
					row_q <= quo_q[ROW_W-1:0];
				end
				ACT_SAVE_SX: sx_q <= quo_q[SCALE_W-1:0];
				ACT_SAVE_SY: sy_q <= quo_q[SCALE_W-1:0];
				ACT_SAVE_OX: ox_q <= prod_q[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && finishing) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctrl.act == ACT_FINISH) begin
			out_q.updated     <= 1'b1;
			out_q.frame       <= frame_q;
			out_q.column      <= col_q[COL_W-1:0];
			out_q.row         <= row_q;
			out_q.playing     <= running_q;
			out_q.uv_scale_x  <= sx_q;
			out_q.uv_scale_y  <= sy_q;
			out_q.uv_offset_x <= ox_q;
			out_q.uv_offset_y <= prod_q[OFFSET_W-1:0];
		end else if (advance && ctrl.act == ACT_FINISH_IDLE) begin
			out_q.updated     <= 1'b0;
			out_q.frame       <= frame_q;
			out_q.column      <= '0;
			out_q.row         <= '0;
			out_q.playing     <= running_q;
			out_q.uv_scale_x  <= '0;
			out_q.uv_scale_y  <= '0;
			out_q.uv_offset_x <= '0;
			out_q.uv_offset_y <= '0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.updated     = out_q.updated;
	assign result.frame       = out_q.frame;
	assign result.column      = out_q.column;
	assign result.row         = out_q.row;
	assign result.playing     = out_q.playing;
	assign result.uv_scale_x  = out_q.uv_scale_x;
	assign result.uv_scale_y  = out_q.uv_scale_y;
	assign result.uv_offset_x = out_q.uv_offset_x;
	assign result.uv_offset_y = out_q.uv_offset_y;

`ifndef ASSERT_OFF
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && ctrl.div_op != DIV_NONE |-> !div_busy)
		else $error("divider started while busy");

	a_stop_only: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(running_q) |-> $past(busy_q && ctrl.act == ACT_STOP))
		else $error("playing cleared outside the stop step");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && ctrl.act == ACT_FINISH |-> col_q < cols_c)
		else $error("column not below sheet columns");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && finishing && out_free |=> !busy_q && out_valid_q)
		else $error("finish step did not post a result");

	a_idle_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q && !accept |=> $stable(frame_q) && $stable(elapsed_q))
		else $error("state changed while idle");
`endif

endmodule

// ===== verif/tb_sprite_sheet_frame_sequencer.sv =====
module tb_sprite_sheet_frame_sequencer;
	timeunit 1ns;
	timeprecision 1ps;
	import ssfs_pkg::*;

	localparam int              SHEET_SIDE_MAX = 64;
	localparam longint unsigned ELAPSED_MAX    = 64'hFFFF_FFFF;
	localparam int              CYCLE_LIMIT    = 2_000_000;
	localparam int              SETTLE_CYCLES  = 200;

	typedef struct {
		logic [SIDE_W-1:0]   columns;
		logic [SIDE_W-1:0]   rows;
		logic [COUNT_W-1:0]  frame_limit;
		logic [PERIOD_W-1:0] frame_period;
		logic                looping;
		logic [START_W-1:0]  start_frame;
	} sheet_t;

	class frame_tracker;
		logic [SIDE_W-1:0]   columns;
		logic [SIDE_W-1:0]   rows;
		logic [COUNT_W-1:0]  frame_limit;
		logic [PERIOD_W-1:0] frame_period;
		logic                looping;
		logic [START_W-1:0]  start_frame;
		longint unsigned     elapsed;
		logic [FRAME_W-1:0]  frame_index;
		logic                running;
		res_t                frames_due[$];
		int                  mismatches;
		int                  checked;
		int                  skipped;
		int                  stops;

		function new();
			columns      = 1;
			rows         = 1;
			frame_limit  = 0;
			frame_period = 1000;
			looping      = 1'b1;
			start_frame  = 0;
			elapsed      = 0;
			frame_index  = 0;
			running      = 1'b1;
			mismatches   = 0;
			checked      = 0;
			skipped      = 0;
			stops        = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_COLUMNS:      columns      = d[SIDE_W-1:0];
				REG_ROWS:         rows         = d[SIDE_W-1:0];
				REG_FRAME_LIMIT:  frame_limit  = d[COUNT_W-1:0];
				REG_FRAME_PERIOD: frame_period = d[PERIOD_W-1:0];
				REG_LOOPING:      looping      = d[0];
				REG_START_FRAME:  start_frame  = d[START_W-1:0];
				default: ;
			endcase
		endfunction

		// Advance the animation by one step request and queue the frame it shows.
		function void note_step(logic [DELTA_W-1:0] delta, logic restart);
			longint unsigned cols, rws, total, count, period, q, steps;
			longint unsigned sx, sy, absf, col, row;
			logic            was_running;
			res_t            r;
			cols = (columns > SHEET_SIDE_MAX) ? SHEET_SIDE_MAX : columns;
			rws  = (rows > SHEET_SIDE_MAX) ? SHEET_SIDE_MAX : rows;
			r = '0;
			if (restart) begin
				elapsed     = 0;
				frame_index = 0;
				running     = 1'b1;
			end
			if (!running || cols == 0 || rws == 0) begin
				r.frame   = frame_index;
				r.playing = running;
				skipped++;
				frames_due.push_back(r);
				return;
			end
			was_running = running;
			total = cols * rws;
			count = (frame_limit != 0 && frame_limit < total) ? frame_limit : total;
			if (count > FRAME_CAP)
				count = FRAME_CAP;
			elapsed = (elapsed > ELAPSED_MAX - delta) ? ELAPSED_MAX : elapsed + delta;
			period = frame_period;
			if (period != 0) begin
				q = elapsed / period;
				// frame left past a shrunken limit: first period only wraps or stops
				if (q != 0 && frame_index >= count) begin
					q--;
					elapsed -= period;
					if (looping) begin
						frame_index = 0;
					end else begin
						frame_index = FRAME_W'(count - 1);
						running     = 1'b0;
						q           = 0;
					end
				end
				if (q != 0) begin
					if (looping) begin
						frame_index = FRAME_W'((frame_index + q) % count);
						elapsed -= q * period;
					end else begin
						steps = count - frame_index;
						if (q >= steps) begin
							elapsed -= steps * period;
							frame_index = FRAME_W'(count - 1);
							running     = 1'b0;
						end else begin
							frame_index = FRAME_W'(frame_index + q);
							elapsed -= q * period;
						end
					end
				end
			end
			if (was_running && !running)
				stops++;
			sx   = (Q16_ONE + cols / 2) / cols;
			sy   = (Q16_ONE + rws / 2) / rws;
			absf = start_frame + frame_index;
			col  = absf % cols;
			row  = absf / cols;
			r.updated     = 1'b1;
			r.frame       = frame_index;
			r.column      = COL_W'(col);
			r.row         = ROW_W'(row);
			r.playing     = running;
			r.uv_scale_x  = SCALE_W'(sx);
			r.uv_scale_y  = SCALE_W'(sy);
			r.uv_offset_x = OFFSET_W'(col * sx);
			r.uv_offset_y = OFFSET_W'(row * sy);
			frames_due.push_back(r);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			mismatches++;
			if (mismatches <= 100)
				$display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
					checked, what, got, want);
		endtask

		task check_result(res_t got);
			res_t want;
			if (frames_due.size() == 0) begin
				report("result with no request pending", got.frame, 0);
				return;
			end
			want = frames_due.pop_front();
			checked++;
			if (got.updated !== want.updated)
				report("updated", got.updated, want.updated);
			if (got.frame !== want.frame)
				report("frame", got.frame, want.frame);
			if (got.column !== want.column)
				report("column", got.column, want.column);
			if (got.row !== want.row)
				report("row", got.row, want.row);
			if (got.playing !== want.playing)
				report("playing", got.playing, want.playing);
			if (got.uv_scale_x !== want.uv_scale_x)
				report("uv_scale_x", got.uv_scale_x, want.uv_scale_x);
			if (got.uv_scale_y !== want.uv_scale_y)
				report("uv_scale_y", got.uv_scale_y, want.uv_scale_y);
			if (got.uv_offset_x !== want.uv_offset_x)
				report("uv_offset_x", got.uv_offset_x, want.uv_offset_x);
			if (got.uv_offset_y !== want.uv_offset_y)
				report("uv_offset_y", got.uv_offset_y, want.uv_offset_y);
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ssfs_step_if   step_ch();
	ssfs_result_if res_ch();

	frame_tracker tracker = new();

	int send_idle_pct;
	int recv_idle_pct;
	int calm;
	int sheet_settings;
	int cycle_count;

	sprite_sheet_frame_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step_ch),
		.result    (res_ch)
	);

	always #5 clk = ~clk;

	function automatic bit chance(int pct);
		return $urandom_range(99) < pct;
	endfunction

	// Random receiver stalls, broken by stretches where both sides run flat out.
	always @(negedge clk) begin
		if (calm != 0)
			calm <= calm - 1;
		else if ($urandom_range(399) == 0)
			calm <= $urandom_range(200, 30);
		res_ch.ready <= (calm != 0) || !chance(recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			tracker.check_result('{
				updated:     res_ch.updated,
				frame:       res_ch.frame,
				column:      res_ch.column,
				row:         res_ch.row,
				playing:     res_ch.playing,
				uv_scale_x:  res_ch.uv_scale_x,
				uv_scale_y:  res_ch.uv_scale_y,
				uv_offset_x: res_ch.uv_offset_x,
				uv_offset_y: res_ch.uv_offset_y
			});
	end

	// Leave valid high on return so a back-to-back request needs no extra edge.
	task automatic offer_step(logic [DELTA_W-1:0] delta, logic restart);
		int gap;
		gap = 0;
		if (calm == 0) begin
			while (chance(send_idle_pct))
				gap++;
			if (gap != 0 && chance(send_idle_pct / 4))
				gap += $urandom_range(160);
		end
		if (gap != 0) begin
			@(negedge clk) step_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		step_ch.valid      <= 1'b1;
		step_ch.delta_time <= delta;
		step_ch.restart    <= restart;
		do @(posedge clk); while (!step_ch.ready);
		tracker.note_step(delta, restart);
	endtask

	task automatic drain_steps();
		@(negedge clk) step_ch.valid <= 1'b0;
		while (tracker.frames_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value, int width, bit junk);
		logic [CFG_DATA_W-1:0] data;
		data = value;
		// unused upper bits must be ignored
		if (junk)
			data = data | (CFG_DATA_W'($urandom()) << width);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		tracker.set_reg(idx, data);
	endtask

	task automatic program_sheet(sheet_t s, bit junk);
		drain_steps();
		write_reg(REG_COLUMNS, s.columns, SIDE_W, junk);
		write_reg(REG_ROWS, s.rows, SIDE_W, junk);
		write_reg(REG_FRAME_LIMIT, s.frame_limit, COUNT_W, junk);
		write_reg(REG_FRAME_PERIOD, s.frame_period, PERIOD_W, junk);
		write_reg(REG_LOOPING, s.looping, 1, junk);
		write_reg(REG_START_FRAME, s.start_frame, START_W, junk);
		@(negedge clk) cfg_we <= 1'b0;
		sheet_settings++;
	endtask

	function automatic logic [SIDE_W-1:0] draw_side();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 4)
			return '0;
		if (pick < 10)
			return SIDE_W'($urandom_range(127, 65));
		if (pick < 20)
			return SIDE_W'(1);
		if (pick < 30)
			return SIDE_W'(SHEET_SIDE_MAX);
		return SIDE_W'($urandom_range(SHEET_SIDE_MAX, 1));
	endfunction

	function automatic sheet_t draw_sheet();
		sheet_t      s;
		int unsigned pick, cells;
		s.columns = draw_side();
		s.rows    = draw_side();
		cells = ((s.columns > SHEET_SIDE_MAX) ? SHEET_SIDE_MAX : s.columns)
			* ((s.rows > SHEET_SIDE_MAX) ? SHEET_SIDE_MAX : s.rows);
		if (cells == 0)
			cells = 1;
		pick = $urandom_range(99);
		if (pick < 25)
			s.frame_limit = 0;
		else if (pick < 30)
			s.frame_limit = '1;
		else if (pick < 35)
			s.frame_limit = FRAME_CAP;
		else if (pick < 85)
			s.frame_limit = COUNT_W'($urandom_range(cells, 1));
		else
			s.frame_limit = COUNT_W'($urandom());
		pick = $urandom_range(99);
		if (pick < 5)
			s.frame_period = 0;
		else if (pick < 10)
			s.frame_period = 1;
		else if (pick < 15)
			s.frame_period = '1;
		else if (pick < 60)
			s.frame_period = PERIOD_W'($urandom_range(300, 1));
		else if (pick < 90)
			s.frame_period = PERIOD_W'($urandom_range(70000, 1));
		else
			s.frame_period = PERIOD_W'($urandom());
		s.looping = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 30)
			s.start_frame = 0;
		else if (pick < 40)
			s.start_frame = '1;
		else
			s.start_frame = START_W'($urandom());
		return s;
	endfunction

	// Mostly a few periods per step so frames wrap and stop often.
	function automatic logic [DELTA_W-1:0] draw_delta(logic [PERIOD_W-1:0] period);
		int unsigned pick, span;
		pick = $urandom_range(99);
		if (pick < 5)
			return '0;
		if (pick < 10)
			return '1;
		if (pick < 30 || period == 0)
			return DELTA_W'($urandom());
		span = (period > 21845) ? 65535 : period * 3;
		return DELTA_W'($urandom_range(span));
	endfunction

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("stopped after %0d cycles, %0d results outstanding",
			cycle_count, tracker.frames_due.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic restart_now;
		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_COLUMNS;
		cfg_data           = '0;
		step_ch.valid      = 1'b0;
		step_ch.delta_time = '0;
		step_ch.restart    = 1'b0;
		res_ch.ready       = 1'b0;
		calm               = 0;
		sheet_settings     = 0;
		send_idle_pct      = 21;
		recv_idle_pct      = 83;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// single-frame sheet straight out of reset
		offer_step(0, 1'b0);
		offer_step('1, 1'b0);

		program_sheet('{8, 4, 0, 100, 1'b1, 0}, 1'b0);
		offer_step(100, 1'b0);
		offer_step(350, 1'b0);
		offer_step('1, 1'b0);
		offer_step(0, 1'b1);

		// oversized sheet, limit above the frame cap, last start frame
		program_sheet('{127, 127, 13'h1FFF, 1, 1'b1, 12'hFFF}, 1'b1);
		offer_step('1, 1'b0);
		offer_step(16'h8001, 1'b1);

		// one-shot: run off the end, stay stopped, restart
		program_sheet('{3, 2, 5, 10, 1'b0, 0}, 1'b0);
		offer_step(25, 1'b0);
		offer_step(100, 1'b0);
		offer_step(10, 1'b0);
		offer_step(0, 1'b1);
		offer_step(60, 1'b1);

		// shrink the limit under the current frame, looping then one-shot
		program_sheet('{3, 2, 0, 10, 1'b1, 0}, 1'b0);
		offer_step(50, 1'b1);
		program_sheet('{3, 2, 2, 10, 1'b1, 0}, 1'b0);
		offer_step(30, 1'b0);
		program_sheet('{3, 2, 0, 10, 1'b1, 0}, 1'b0);
		offer_step(50, 1'b1);
		program_sheet('{3, 2, 3, 10, 1'b0, 0}, 1'b0);
		offer_step(10, 1'b0);

		// pile up time with no period, then release it all at once
		program_sheet('{64, 64, 0, 0, 1'b1, 0}, 1'b0);
		repeat (3) offer_step('1, 1'b0);
		program_sheet('{64, 64, FRAME_CAP, 1, 1'b1, 7}, 1'b0);
		offer_step(0, 1'b0);

		// empty sheet, then the longest period
		program_sheet('{0, 5, 0, 100, 1'b1, 0}, 1'b0);
		offer_step(100, 1'b0);
		program_sheet('{5, 0, 0, 100, 1'b1, 0}, 1'b0);
		offer_step(100, 1'b1);
		program_sheet('{5, 5, 0, 24'hFFFFFF, 1'b1, 0}, 1'b0);
		offer_step('1, 1'b0);

		for (int phase = 0; phase < 14; phase++) begin
			if (phase == 5) begin
				send_idle_pct = 83;
				recv_idle_pct = 21;
			end else if (phase == 10) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			program_sheet(draw_sheet(), chance(30));
			for (int n = 0; n < 100; n++) begin
				// restart a stopped animation now and then so most steps do work
				restart_now = tracker.running ? chance(3) : chance(30);
				offer_step(draw_delta(tracker.frame_period), restart_now);
			end
		end

		drain_steps();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("checked %0d steps over %0d sheet settings", tracker.checked, sheet_settings);
		$display("%0d steps skipped while stopped or empty, %0d one-shot runs ended",
			tracker.skipped, tracker.stops);
		if (tracker.mismatches == 0 && tracker.frames_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/ssfs_pkg.sv
sv/ssfs_ifs.sv
sv/sprite_sheet_frame_sequencer.sv
verif/tb_sprite_sheet_frame_sequencer.sv
